// File: design/sv39pt_pkg.sv
// Shared types, widths and codes of the Sv39 page-table map and walk block.
`default_nettype none
package sv39pt_pkg;

    localparam int TABLE_PAGES = 64;
    localparam int ENTRY_W     = 9;
    localparam int PAGE_W      = (TABLE_PAGES > 1) ? $clog2(TABLE_PAGES) : 1;
    localparam int NFP_W       = $clog2(TABLE_PAGES + 1);
    localparam int ADDR_W      = PAGE_W + ENTRY_W;
    localparam int DEPTH       = TABLE_PAGES * (1 << ENTRY_W);
    localparam int PTE_W       = 64;

    localparam int PPN_W    = 44;
    localparam int VA_W     = 39;
    localparam int PA_W     = 56;
    localparam int FLAGS_W  = 10;
    localparam int STATUS_W = 3;
    localparam int OFFS_W   = 12;

    localparam logic [PPN_W-1:0] BASE_PPN_RESET = 44'd524288;

    localparam logic CMD_MAP   = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    localparam logic [STATUS_W-1:0] ST_OK         = 3'd0;
    localparam logic [STATUS_W-1:0] ST_MISALIGNED = 3'd1;
    localparam logic [STATUS_W-1:0] ST_EXHAUSTED  = 3'd2;
    localparam logic [STATUS_W-1:0] ST_UPPER_LEAF = 3'd3;
    localparam logic [STATUS_W-1:0] ST_MAPPED     = 3'd4;
    localparam logic [STATUS_W-1:0] ST_UNMAPPED   = 3'd5;

    localparam logic [FLAGS_W-1:0] FLAG_V   = 10'h001;
    localparam logic [FLAGS_W-1:0] FLAG_RWX = 10'h00E;
    localparam logic [FLAGS_W-1:0] FLAG_VAD = 10'h0C1;

    typedef struct packed {
        logic              we;
        logic              re;
        logic [ADDR_W-1:0] addr;
        logic [PTE_W-1:0]  wdata;
    } t_mem_req;

    typedef struct packed {
        logic                success;
        logic [STATUS_W-1:0] status;
        logic [PA_W-1:0]     out_paddr;
        logic [FLAGS_W-1:0]  out_flags;
    } t_result;

    function automatic logic pte_valid(input logic [PTE_W-1:0] e);
        pte_valid = |(e[FLAGS_W-1:0] & FLAG_V);
    endfunction

    function automatic logic pte_leaf(input logic [PTE_W-1:0] e);
        pte_leaf = |(e[FLAGS_W-1:0] & FLAG_RWX);
    endfunction

endpackage
`default_nettype wire

// File: design/sv39pt_if.sv
// Request, response and configuration channel interfaces.
`default_nettype none
interface sv39pt_req_if import sv39pt_pkg::*; ();
    logic               valid;
    logic               ready;
    logic               cmd;
    logic [VA_W-1:0]    vaddr;
    logic [PA_W-1:0]    paddr;
    logic [FLAGS_W-1:0] perm_flags;

    modport source (output valid, cmd, vaddr, paddr, perm_flags,
                    input ready);
    modport sink   (input valid, cmd, vaddr, paddr, perm_flags,
                    output ready);
endinterface

interface sv39pt_rsp_if import sv39pt_pkg::*; ();
    logic                valid;
    logic                ready;
    logic                success;
    logic [STATUS_W-1:0] status;
    logic [PA_W-1:0]     out_paddr;
    logic [FLAGS_W-1:0]  out_flags;

    modport source (output valid, success, status, out_paddr, out_flags,
                    input ready);
    modport sink   (input valid, success, status, out_paddr, out_flags,
                    output ready);
endinterface

interface sv39pt_cfg_if import sv39pt_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [PPN_W-1:0] data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface
`default_nettype wire

// File: design/sv39pt_table_ram.sv
// Single-port synchronous RAM holding the page-table pool.
`default_nettype none
module sv39pt_table_ram #(
    parameter int DATA_W = 64,
    parameter int DEPTH  = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_addr,
    input  wire logic [DATA_W-1:0]        i_wdata,
    output      logic [DATA_W-1:0]        o_rdata
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

// File: design/sv39pt_walker.sv
// Walk sequencer: clearing pass, three-level map and query walks, pool allocation.
`default_nettype none
module sv39pt_walker import sv39pt_pkg::*; (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic [PPN_W-1:0] i_base_ppn,
    sv39pt_req_if.sink            i_req,
    output      t_mem_req         o_mem,
    input  wire logic [PTE_W-1:0] i_rdata,
    output      logic             o_res_valid,
    output      t_result          o_res,
    input  wire logic             i_res_ready
);

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_READ  = 3'd2;
    localparam logic [2:0] S_CHECK = 3'd3;
    localparam logic [2:0] S_DONE  = 3'd4;

    localparam logic [1:0] LVL_2 = 2'd2;
    localparam logic [1:0] LVL_1 = 2'd1;
    localparam logic [1:0] LVL_0 = 2'd0;

    logic [2:0]          r_state, n_state;
    logic [ADDR_W-1:0]   r_clr_addr, n_clr_addr;
    logic [NFP_W-1:0]    r_nfp, n_nfp;
    logic [1:0]          r_level, n_level;
    logic [PAGE_W-1:0]   r_page, n_page;
    logic                r_cmd, n_cmd;
    logic [VA_W-1:0]     r_va, n_va;
    logic [PA_W-1:0]     r_pa, n_pa;
    logic [FLAGS_W-1:0]  r_fl, n_fl;
    logic [STATUS_W-1:0] r_status, n_status;
    logic [PA_W-1:0]     r_out_pa, n_out_pa;
    logic [FLAGS_W-1:0]  r_out_fl, n_out_fl;

    logic [ENTRY_W-1:0]  vpn;
    logic [ADDR_W-1:0]   walk_addr;
    logic [PPN_W-1:0]    pool_off;
    logic                in_pool;
    logic [PPN_W-1:0]    new_ppn;
    logic                accept;

    assign accept = i_req.valid && i_req.ready;
    assign i_req.ready = (r_state == S_IDLE);

    always_comb begin
        case (r_level)
            LVL_2:   vpn = r_va[38:30];
            LVL_1:   vpn = r_va[29:21];
            default: vpn = r_va[20:12];
        endcase
    end

    assign walk_addr = {r_page, vpn};
    assign pool_off  = i_rdata[PPN_W+FLAGS_W-1:FLAGS_W] - i_base_ppn;
    assign in_pool   = pool_off < PPN_W'(r_nfp);
    assign new_ppn   = i_base_ppn + PPN_W'(r_nfp);

    always_comb begin
        n_state    = r_state;
        n_clr_addr = r_clr_addr;
        n_nfp      = r_nfp;
        n_level    = r_level;
        n_page     = r_page;
        n_cmd      = r_cmd;
        n_va       = r_va;
        n_pa       = r_pa;
        n_fl       = r_fl;
        n_status   = r_status;
        n_out_pa   = r_out_pa;
        n_out_fl   = r_out_fl;
        o_mem      = '0;

        case (r_state)
            S_CLEAR: begin
                o_mem.we   = 1'b1;
                o_mem.addr = r_clr_addr;
                if (r_clr_addr == ADDR_W'(DEPTH - 1)) begin
                    n_state = S_IDLE;
                end else begin
                    n_clr_addr = r_clr_addr + 1'b1;
                end
            end
            S_IDLE: begin
                if (accept) begin
                    n_cmd    = i_req.cmd;
                    n_va     = i_req.vaddr;
                    n_pa     = i_req.paddr;
                    n_fl     = i_req.perm_flags;
                    n_out_pa = '0;
                    n_out_fl = '0;
                    n_level  = LVL_2;
                    n_page   = '0;
                    n_status = ST_OK;
                    if (i_req.cmd == CMD_MAP &&
                        (i_req.vaddr[OFFS_W-1:0] != '0 ||
                         i_req.paddr[OFFS_W-1:0] != '0)) begin
                        n_status = ST_MISALIGNED;
                        n_state  = S_DONE;
                    end else begin
                        n_state = S_READ;
                    end
                end
            end
            S_READ: begin
                o_mem.re   = 1'b1;
                o_mem.addr = walk_addr;
                n_state    = S_CHECK;
            end
            S_CHECK: begin
                o_mem.addr = walk_addr;
                if (r_level != LVL_0) begin
                    if (!pte_valid(i_rdata)) begin
                        if (r_cmd == CMD_QUERY) begin
                            n_status = ST_UNMAPPED;
                            n_state  = S_DONE;
                        end else if (r_nfp >= NFP_W'(TABLE_PAGES)) begin
                            n_status = ST_EXHAUSTED;
                            n_state  = S_DONE;
                        end else begin
                            o_mem.we    = 1'b1;
                            o_mem.wdata = {{(PTE_W-PPN_W-FLAGS_W){1'b0}}, new_ppn, FLAG_V};
                            n_nfp       = r_nfp + 1'b1;
                            n_page      = r_nfp[PAGE_W-1:0];
                            n_level     = r_level - 1'b1;
                            n_state     = S_READ;
                        end
                    end else if (pte_leaf(i_rdata) || !in_pool) begin
                        n_status = (r_cmd == CMD_MAP) ? ST_UPPER_LEAF : ST_UNMAPPED;
                        n_state  = S_DONE;
                    end else begin
                        n_page  = pool_off[PAGE_W-1:0];
                        n_level = r_level - 1'b1;
                        n_state = S_READ;
                    end
                end else if (r_cmd == CMD_MAP) begin
                    if (pte_valid(i_rdata)) begin
                        n_status = ST_MAPPED;
                    end else begin
                        o_mem.we    = 1'b1;
                        o_mem.wdata = {{(PTE_W-PPN_W-FLAGS_W){1'b0}},
                                       r_pa[PA_W-1:OFFS_W], r_fl | FLAG_VAD};
                        n_status    = ST_OK;
                    end
                    n_state = S_DONE;
                end else begin
                    if (pte_valid(i_rdata) && pte_leaf(i_rdata)) begin
                        n_out_pa = {i_rdata[PPN_W+FLAGS_W-1:FLAGS_W], r_va[OFFS_W-1:0]};
                        n_out_fl = i_rdata[FLAGS_W-1:0];
                        n_status = ST_OK;
                    end else begin
                        n_status = ST_UNMAPPED;
                    end
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLEAR;
            r_clr_addr <= '0;
            r_nfp      <= NFP_W'(1);
            r_level    <= LVL_2;
            r_page     <= '0;
        end else begin
            r_state    <= n_state;
            r_clr_addr <= n_clr_addr;
            r_nfp      <= n_nfp;
            r_level    <= n_level;
            r_page     <= n_page;
        end
        r_cmd    <= n_cmd;
        r_va     <= n_va;
        r_pa     <= n_pa;
        r_fl     <= n_fl;
        r_status <= n_status;
        r_out_pa <= n_out_pa;
        r_out_fl <= n_out_fl;
    end

    assign o_res_valid     = (r_state == S_DONE);
    assign o_res.success   = (r_status == ST_OK);
    assign o_res.status    = r_status;
    assign o_res.out_paddr = r_out_pa;
    assign o_res.out_flags = r_out_fl;

`ifndef SYNTHESIS
    a_nfp_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_nfp != '0 && r_nfp <= NFP_W'(TABLE_PAGES))
        else $error("free page counter out of range");

    a_page_in_pool: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_mem.re || o_mem.we) && r_state != S_CLEAR |-> NFP_W'(r_page) < r_nfp)
        else $error("walk touches a page that is not allocated");

    a_nfp_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && r_nfp != $past(r_nfp) |->
            $past(o_mem.we) && r_nfp == NFP_W'($past(r_nfp) + 1'b1))
        else $error("free page counter moved without a linking write");

    a_accept_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.valid && i_req.ready |=> r_state == S_READ || r_state == S_DONE)
        else $error("accepted request did not start a walk");

    a_done_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_DONE && !i_res_ready |=> r_state == S_DONE && $stable(r_status))
        else $error("result dropped while stalled");
`endif

endmodule
`default_nettype wire

// File: design/sv39pt_result_reg.sv
// Output register decoupling the walker from the response channel.
`default_nettype none
module sv39pt_result_reg import sv39pt_pkg::*; (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_valid,
    input  wire t_result i_result,
    output      logic    o_ready,
    sv39pt_rsp_if.source o_rsp
);

    logic    r_valid;
    t_result r_result;

    assign o_ready = !r_valid || o_rsp.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
        if (o_ready && i_valid) begin
            r_result <= i_result;
        end
    end

    assign o_rsp.valid     = r_valid;
    assign o_rsp.success   = r_result.success;
    assign o_rsp.status    = r_result.status;
    assign o_rsp.out_paddr = r_result.out_paddr;
    assign o_rsp.out_flags = r_result.out_flags;

endmodule
`default_nettype wire

// File: design/sv39_page_table_map_and_walk.sv
// Sv39 page-table pool with map and query walks.
//
// i_req carries one request: cmd 0 maps vaddr to paddr with perm_flags
// (V, A and D added), cmd 1 queries the translation of vaddr.
// o_rsp returns one response per request: success, status, and for a query the
// translated address and the leaf's low ten flag bits.
// i_cfg writes table_base_ppn, the page number of pool page 0; write it only idle.
// A walk runs on the single port of the table RAM, one read state and one check
// state per level, with any allocation or leaf write done in the check state.
// A misaligned map skips the walk and goes straight to its response; a new request
// is taken only after the last one has handed its response to the output register.
// After reset the RAM is cleared one entry a cycle, all TABLE_PAGES * 512 entries
// (32768 at 64 pages); i_req is not ready during that pass, i_cfg is.
// A stalled response is held in the output register; the walker finishes the
// next request and waits there until the register frees.
`default_nettype none
module sv39_page_table_map_and_walk import sv39pt_pkg::*; (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    sv39pt_req_if.sink   i_req,
    sv39pt_rsp_if.source o_rsp,
    sv39pt_cfg_if.sink   i_cfg
);

    logic [PPN_W-1:0] r_base_ppn;
    t_mem_req         mem_req;
    logic [PTE_W-1:0] mem_rdata;
    logic             res_valid;
    logic             res_ready;
    t_result          res;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base_ppn <= BASE_PPN_RESET;
        end else if (i_cfg.valid) begin
            r_base_ppn <= i_cfg.data;
        end
    end

    sv39pt_walker u_walker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_base_ppn  (r_base_ppn),
        .i_req       (i_req),
        .o_mem       (mem_req),
        .i_rdata     (mem_rdata),
        .o_res_valid (res_valid),
        .o_res       (res),
        .i_res_ready (res_ready)
    );

    sv39pt_table_ram #(
        .DATA_W (PTE_W),
        .DEPTH  (DEPTH)
    ) u_table_ram (
        .i_clk   (i_clk),
        .i_we    (mem_req.we),
        .i_re    (mem_req.re),
        .i_addr  (mem_req.addr),
        .i_wdata (mem_req.wdata),
        .o_rdata (mem_rdata)
    );

    sv39pt_result_reg u_result_reg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (res_valid),
        .i_result (res),
        .o_ready  (res_ready),
        .o_rsp    (o_rsp)
    );

endmodule
`default_nettype wire
